// ===== design/concatenation_residue_sieve_defines.svh =====
// assertion macros shared by the sieve checker
`ifndef CONCATENATION_RESIDUE_SIEVE_DEFINES_SVH
`define CONCATENATION_RESIDUE_SIEVE_DEFINES_SVH

// same-cycle implication, held off during reset
`define CRS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define CRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/crs_pkg.sv =====
// shared constants, types and helpers of the concatenation residue sieve
`timescale 1ns / 1ps

package crs_pkg;

   localparam int LANE_COUNT    = 4;
   localparam int MODULUS_BITS  = 62;
   localparam int TERM_BITS     = 30;
   localparam int SEED_BITS     = 30;
   localparam int SRC_BITS      = (MODULUS_BITS > SEED_BITS) ? MODULUS_BITS : SEED_BITS;
   localparam int SUM_BITS      = MODULUS_BITS + 2;
   localparam int CNT_BITS      = $clog2(SRC_BITS + 1);
   localparam int CSR_IDX_BITS  = $clog2(LANE_COUNT + 2);
   localparam int CSR_DATA_BITS = SRC_BITS;

   localparam logic [SEED_BITS-1:0]    SEED_RESET    = SEED_BITS'(2357);
   localparam logic [MODULUS_BITS-1:0] MODULUS_RESET = MODULUS_BITS'(3);
   localparam logic [CSR_IDX_BITS-1:0] SEED_INDEX    = CSR_IDX_BITS'(LANE_COUNT);

   // powers of ten, index is the exponent
   localparam logic [TERM_BITS-1:0] POW10 [10] = '{
      TERM_BITS'(1), TERM_BITS'(10), TERM_BITS'(100), TERM_BITS'(1000),
      TERM_BITS'(10000), TERM_BITS'(100000), TERM_BITS'(1000000),
      TERM_BITS'(10000000), TERM_BITS'(100000000), TERM_BITS'(1000000000)
   };
   localparam logic [TERM_BITS-1:0] TERM_LIMIT = POW10[9];

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_RED,
      ST_FIX,
      ST_MUL,
      ST_WB,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic src_load;
      logic src_seed;
      logic acc_clear;
      logic red_step;
      logic mul_step;
      logic commit;
      logic stale_clr;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic restart;
      logic too_large;
      logic stale;
      logic out_free;
   } stat_type;

   // ten to the number of decimal digits of the term
   function automatic logic [TERM_BITS-1:0] digit_scale(input logic [TERM_BITS-1:0] term);
      logic [TERM_BITS-1:0] scale;
      scale = POW10[1];
      for (int k = 1; k <= 8; k++) begin
         if (term >= POW10[k]) begin
            scale = POW10[k+1];
         end
      end
      return scale;
   endfunction

endpackage

// ===== design/crs_ifs.sv =====
// channel interfaces of the concatenation residue sieve
`timescale 1ns / 1ps

interface crs_req_if;
   logic                            valid;
   logic                            ready;
   logic [crs_pkg::TERM_BITS-1:0]   term;
   logic                            restart;
   modport source (output valid, output term, output restart, input ready);
   modport sink   (input valid, input term, input restart, output ready);
endinterface

interface crs_rsp_if;
   logic valid;
   logic ready;
   logic divides_a;
   logic divides_b;
   logic divides_c;
   logic divides_d;
   logic term_too_large;
   modport source (output valid, output divides_a, output divides_b, output divides_c,
                   output divides_d, output term_too_large, input ready);
   modport sink   (input valid, input divides_a, input divides_b, input divides_c,
                   input divides_d, input term_too_large, output ready);
endinterface

interface crs_csr_if;
   logic                                valid;
   logic                                ready;
   logic [crs_pkg::CSR_IDX_BITS-1:0]    index;
   logic [crs_pkg::CSR_DATA_BITS-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/crs_lane.sv =====
// one sieve lane: residue register and bit-serial modular reduce / multiply-add
`timescale 1ns / 1ps

module crs_lane (
   input  logic                               clock,
   input  logic                               reset,
   input  crs_pkg::cmd_type                   cmd,
   input  logic [crs_pkg::SEED_BITS-1:0]      seed,
   input  logic [crs_pkg::MODULUS_BITS-1:0]   modulus,
   input  logic                               tbit,
   input  logic                               sbit,
   output logic                               zero
);

   logic [crs_pkg::MODULUS_BITS-1:0] residue_ff, residue_in;
   logic [crs_pkg::MODULUS_BITS-1:0] acc_ff, acc_in;
   logic [crs_pkg::SRC_BITS-1:0]     src_ff, src_in;

   logic [crs_pkg::MODULUS_BITS-1:0] eff_mod;
   logic [crs_pkg::SUM_BITS-1:0]     mod_w, mod2_w, sum, reduced;
   logic                             add_bit;
   logic [crs_pkg::MODULUS_BITS-1:0] addend;

   // modulus zero or one acts as one
   assign eff_mod = (modulus < crs_pkg::MODULUS_BITS'(2)) ? crs_pkg::MODULUS_BITS'(1) : modulus;
   assign mod_w   = crs_pkg::SUM_BITS'(eff_mod);
   assign mod2_w  = {mod_w[crs_pkg::SUM_BITS-2:0], 1'b0};

   // acc*2 + bit (+ residue when the scale bit is set), always below three moduli
   assign add_bit = cmd.red_step ? src_ff[crs_pkg::SRC_BITS-1] : tbit;
   assign addend  = (cmd.mul_step && sbit) ? residue_ff : '0;
   assign sum     = {1'b0, acc_ff, add_bit} + crs_pkg::SUM_BITS'(addend);

   always_comb begin
      if (sum >= mod2_w) begin
         reduced = sum - mod2_w;
      end else if (sum >= mod_w) begin
         reduced = sum - mod_w;
      end else begin
         reduced = sum;
      end
   end

   always_comb begin
      acc_in     = acc_ff;
      src_in     = src_ff;
      residue_in = residue_ff;
      if (cmd.acc_clear) begin
         acc_in = '0;
      end else if (cmd.red_step || cmd.mul_step) begin
         acc_in = reduced[crs_pkg::MODULUS_BITS-1:0];
      end
      if (cmd.src_load) begin
         if (cmd.src_seed) begin
            src_in = crs_pkg::SRC_BITS'(seed) << (crs_pkg::SRC_BITS - crs_pkg::SEED_BITS);
         end else begin
            src_in = crs_pkg::SRC_BITS'(residue_ff)
                     << (crs_pkg::SRC_BITS - crs_pkg::MODULUS_BITS);
         end
      end else if (cmd.red_step) begin
         src_in = src_ff << 1;
      end
      if (cmd.commit) begin
         residue_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         residue_ff <= '0;
      end else begin
         residue_ff <= residue_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      src_ff <= src_in;
   end

   assign zero = (residue_ff == '0);

endmodule

// ===== design/crs_dpath.sv =====
// datapath: config registers, term and scale shifters, lanes, result register
`timescale 1ns / 1ps

module crs_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  crs_pkg::cmd_type                      cmd,
   output crs_pkg::stat_type                     stat,
   input  logic                                  csr_we,
   input  logic [crs_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [crs_pkg::CSR_DATA_BITS-1:0]     csr_data,
   input  logic [crs_pkg::TERM_BITS-1:0]         req_term,
   input  logic                                  req_restart,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [crs_pkg::LANE_COUNT-1:0]        rsp_divides,
   output logic                                  rsp_too_large
);

   logic [crs_pkg::MODULUS_BITS-1:0] mod_ff [crs_pkg::LANE_COUNT];
   logic [crs_pkg::SEED_BITS-1:0]    seed_ff;
   logic                             stale_ff;
   logic [crs_pkg::TERM_BITS-1:0]    term_sh_ff, term_sh_in;
   logic [crs_pkg::TERM_BITS-1:0]    scale_sh_ff, scale_sh_in;
   logic                             restart_ff, too_large_ff;
   logic                             rsp_valid_ff;
   logic [crs_pkg::LANE_COUNT-1:0]   divides_ff;
   logic                             out_large_ff;
   logic [crs_pkg::LANE_COUNT-1:0]   lane_zero;
   logic                             mod_we;

   // any modulus write leaves stored residues possibly above the new modulus
   always_comb begin
      mod_we = 1'b0;
      for (int i = 0; i < crs_pkg::LANE_COUNT; i++) begin
         if (csr_we && csr_index == crs_pkg::CSR_IDX_BITS'(i)) begin
            mod_we = 1'b1;
         end
      end
   end

   for (genvar g = 0; g < crs_pkg::LANE_COUNT; g++) begin : g_mod
      always_ff @(posedge clock) begin
         if (reset) begin
            mod_ff[g] <= crs_pkg::MODULUS_RESET;
         end else if (csr_we && csr_index == crs_pkg::CSR_IDX_BITS'(g)) begin
            mod_ff[g] <= csr_data[crs_pkg::MODULUS_BITS-1:0];
         end
      end

      crs_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .cmd     (cmd),
         .seed    (seed_ff),
         .modulus (mod_ff[g]),
         .tbit    (term_sh_ff[crs_pkg::TERM_BITS-1]),
         .sbit    (scale_sh_ff[crs_pkg::TERM_BITS-1]),
         .zero    (lane_zero[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= crs_pkg::SEED_RESET;
         stale_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == crs_pkg::SEED_INDEX) begin
            seed_ff <= csr_data[crs_pkg::SEED_BITS-1:0];
         end
         if (mod_we) begin
            stale_ff <= 1'b1;
         end else if (cmd.stale_clr) begin
            stale_ff <= 1'b0;
         end
      end
   end

   // term and scale go out msb first, one bit per multiply step
   always_comb begin
      term_sh_in  = term_sh_ff;
      scale_sh_in = scale_sh_ff;
      if (cmd.capture) begin
         term_sh_in  = req_term;
         scale_sh_in = crs_pkg::digit_scale(req_term);
      end else if (cmd.mul_step) begin
         term_sh_in  = term_sh_ff << 1;
         scale_sh_in = scale_sh_ff << 1;
      end
   end

   always_ff @(posedge clock) begin
      term_sh_ff  <= term_sh_in;
      scale_sh_ff <= scale_sh_in;
      if (cmd.capture) begin
         restart_ff   <= req_restart;
         too_large_ff <= (req_term >= crs_pkg::TERM_LIMIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         divides_ff   <= too_large_ff ? '0 : lane_zero;
         out_large_ff <= too_large_ff;
      end
   end

   assign stat.restart   = restart_ff;
   assign stat.too_large = too_large_ff;
   assign stat.stale     = stale_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_divides   = divides_ff;
   assign rsp_too_large = out_large_ff;

endmodule

// ===== design/crs_ctrl.sv =====
// controller: sequences reduce, multiply-add, writeback and result hand-off
`timescale 1ns / 1ps

module crs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  crs_pkg::stat_type  stat,
   output crs_pkg::cmd_type   cmd
);

   crs_pkg::state_type              state_ff, state_in;
   logic [crs_pkg::CNT_BITS-1:0]    cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crs_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         crs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = crs_pkg::ST_PREP;
            end
         end
         crs_pkg::ST_PREP: begin
            cmd.acc_clear = 1'b1;
            if (stat.restart || stat.stale) begin
               // seed reload or residue cleanup after a modulus change
               cmd.src_load = 1'b1;
               cmd.src_seed = stat.restart;
               cnt_in       = stat.restart ? crs_pkg::CNT_BITS'(crs_pkg::SEED_BITS - 1)
                                           : crs_pkg::CNT_BITS'(crs_pkg::MODULUS_BITS - 1);
               state_in     = crs_pkg::ST_RED;
            end else if (stat.too_large) begin
               state_in = crs_pkg::ST_DONE;
            end else begin
               cnt_in   = crs_pkg::CNT_BITS'(crs_pkg::TERM_BITS - 1);
               state_in = crs_pkg::ST_MUL;
            end
         end
         crs_pkg::ST_RED: begin
            cmd.red_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = crs_pkg::ST_FIX;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         crs_pkg::ST_FIX: begin
            cmd.commit    = 1'b1;
            cmd.stale_clr = 1'b1;
            cmd.acc_clear = 1'b1;
            if (stat.too_large) begin
               state_in = crs_pkg::ST_DONE;
            end else begin
               cnt_in   = crs_pkg::CNT_BITS'(crs_pkg::TERM_BITS - 1);
               state_in = crs_pkg::ST_MUL;
            end
         end
         crs_pkg::ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = crs_pkg::ST_WB;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         crs_pkg::ST_WB: begin
            cmd.commit = 1'b1;
            state_in   = crs_pkg::ST_DONE;
         end
         crs_pkg::ST_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = crs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = crs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/concatenation_residue_sieve.sv =====
// top level of the concatenation residue sieve
`timescale 1ns / 1ps

// Four lanes keep (concatenation mod modulus) for their own modulus; each req word
// appends a term of up to nine decimal digits, and each rsp word flags the lanes
// whose residue is now zero (or term_too_large for a term of ten digits). Configuration
// registers 0 to 3 are the lane moduli and 4 is the seed loaded on restart; write them
// only while no word is in flight. A term passes from accept through the prepare state, a
// 30-step bit-serial multiply-add per lane (one scale and term bit per cycle), writeback
// and the result hand-off back to idle. A restart adds a reduction of the 30-bit
// seed; the first term after a modulus write adds a reduction of the 62-bit
// residue. A too-large term without either skips the multiply-add. The rsp
// word sits in an output register, so the next req word is taken while it waits.
module concatenation_residue_sieve (
   input  logic        clock,
   input  logic        reset,
   crs_req_if.sink     req_bus,
   crs_rsp_if.source   rsp_bus,
   crs_csr_if.sink     csr_bus
);

   crs_pkg::cmd_type                   cmd;
   crs_pkg::stat_type                  stat;
   logic [crs_pkg::LANE_COUNT-1:0]     divides;

   assign csr_bus.ready = 1'b1;

   crs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   crs_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .csr_we        (csr_bus.valid),
      .csr_index     (csr_bus.index),
      .csr_data      (csr_bus.data),
      .req_term      (req_bus.term),
      .req_restart   (req_bus.restart),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_divides   (divides),
      .rsp_too_large (rsp_bus.term_too_large)
   );

   assign rsp_bus.divides_a = divides[0];
   assign rsp_bus.divides_b = divides[1];
   assign rsp_bus.divides_c = divides[2];
   assign rsp_bus.divides_d = divides[3];

endmodule

// ===== design/crs_checker.sv =====
// port-level checker for the concatenation residue sieve, bound to the top level
`timescale 1ns / 1ps
`include "concatenation_residue_sieve_defines.svh"

module crs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic divides_a,
   input logic divides_b,
   input logic divides_c,
   input logic divides_d,
   input logic term_too_large
);

   // an oversized term never reports a divisor
   `CRS_ASSERT_NOW(a_large_no_div, clock, reset, rsp_valid && term_too_large, !(divides_a || divides_b || divides_c || divides_d), "divides flag with oversized term")

   // one word at a time: after an accept the block is busy
   `CRS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "req taken on back-to-back cycles")

   // a held rsp word stays valid
   `CRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp word dropped while stalled")

   // nothing to report right out of reset
   `CRS_ASSERT_NOW(a_rsp_after_reset, clock, reset, $past(reset), !rsp_valid, "rsp valid right after reset")

endmodule

bind concatenation_residue_sieve crs_checker u_crs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .divides_a      (rsp_bus.divides_a),
   .divides_b      (rsp_bus.divides_b),
   .divides_c      (rsp_bus.divides_c),
   .divides_d      (rsp_bus.divides_d),
   .term_too_large (rsp_bus.term_too_large)
);

// ===== tb/sv/concatenation_residue_sieve_tb.sv =====
// self-checking testbench of the concatenation residue sieve: directed table and setups, then random phases
`timescale 1ns / 1ps

module concatenation_residue_sieve_tb;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int DRAIN_CYCLES   = 150;
   localparam int SQUEEZE_CYCLES = 400;
   localparam int PHASE_COUNT    = 6;
   localparam int PHASE_ITEMS    = 72;
   localparam int DIRECTED_COUNT = 22;

   localparam logic [crs_pkg::MODULUS_BITS-1:0] MODULUS_MAX = '1;
   localparam logic [crs_pkg::TERM_BITS-1:0]    TERM_MAX    = '1;
   localparam logic [crs_pkg::SEED_BITS-1:0]    SEED_MAX    =
      crs_pkg::SEED_BITS'(999999999);
   localparam logic [crs_pkg::TERM_BITS-1:0]    TOO_LARGE_AT =
      crs_pkg::TERM_BITS'(1000000000);
   localparam int SMALL_PRIMES [8] = '{3, 7, 11, 13, 17, 37, 41, 101};

   typedef struct packed {
      logic divides_a;
      logic divides_b;
      logic divides_c;
      logic divides_d;
      logic term_too_large;
   } sieve_flags_type;

   typedef struct packed {
      logic [crs_pkg::TERM_BITS-1:0] term;
      logic                          restart;
      logic                          typed;
      sieve_flags_type               flags;
   } sieve_row_type;

   localparam sieve_flags_type ALL_DIVIDE = 5'b11110;
   localparam sieve_flags_type TOO_LARGE  = 5'b00001;
   localparam sieve_flags_type NO_FLAGS   = 5'b00000;

   // rows marked typed carry their result; the others go through the predictor
   localparam sieve_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{30'd0,          1'b0, 1'b1, ALL_DIVIDE},
      '{30'd999999999,  1'b0, 1'b1, ALL_DIVIDE},
      '{30'd1000000000, 1'b0, 1'b1, TOO_LARGE},
      '{TERM_MAX,       1'b1, 1'b1, TOO_LARGE},
      '{30'd9,          1'b0, 1'b0, NO_FLAGS},
      '{30'd10,         1'b0, 1'b0, NO_FLAGS},
      '{30'd99,         1'b1, 1'b0, NO_FLAGS},
      '{30'd100,        1'b0, 1'b0, NO_FLAGS},
      '{30'd999,        1'b0, 1'b0, NO_FLAGS},
      '{30'd1000,       1'b0, 1'b0, NO_FLAGS},
      '{30'd9999,       1'b1, 1'b0, NO_FLAGS},
      '{30'd10000,      1'b0, 1'b0, NO_FLAGS},
      '{30'd99999,      1'b0, 1'b0, NO_FLAGS},
      '{30'd100000,     1'b0, 1'b0, NO_FLAGS},
      '{30'd999999,     1'b1, 1'b0, NO_FLAGS},
      '{30'd1000000,    1'b0, 1'b0, NO_FLAGS},
      '{30'd9999999,    1'b0, 1'b0, NO_FLAGS},
      '{30'd10000000,   1'b0, 1'b0, NO_FLAGS},
      '{30'd99999999,   1'b0, 1'b0, NO_FLAGS},
      '{30'd100000000,  1'b1, 1'b0, NO_FLAGS},
      '{30'd1000000000, 1'b1, 1'b1, TOO_LARGE},
      '{30'd0,          1'b0, 1'b0, NO_FLAGS}
   };

   logic clock;
   logic reset;

   crs_req_if req_if ();
   crs_rsp_if rsp_if ();
   crs_csr_if csr_if ();

   concatenation_residue_sieve u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // predictor state
   logic [crs_pkg::MODULUS_BITS-1:0] lane_mod [crs_pkg::LANE_COUNT];
   logic [crs_pkg::MODULUS_BITS-1:0] lane_rem [crs_pkg::LANE_COUNT];
   logic [crs_pkg::SEED_BITS-1:0]    seed_reg;

   sieve_flags_type flags_due [$];
   sieve_flags_type due_flags;

   int  errors;
   int  quiet_cycles;
   int  items_sent;
   int  restarts_sent;
   int  too_large_sent;
   int  csr_writes;
   int  results_checked;
   int  lane_hits;
   bit  calm_phase;
   bit  squeeze_rsp;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // residue update of every lane for one term, plus the flags it produces
   function automatic sieve_flags_type sieve_predict(
         input logic [crs_pkg::TERM_BITS-1:0] term, input logic restart);
      sieve_flags_type                   flags;
      logic [127:0]                      wide;
      logic [crs_pkg::MODULUS_BITS-1:0]  m;
      longint unsigned                   scale;
      logic [crs_pkg::LANE_COUNT-1:0]    hit;
      logic                              too_large;
      too_large = term >= TOO_LARGE_AT;
      scale = 10;
      while (term >= scale && scale < 1000000000) begin
         scale = scale * 10;
      end
      for (int i = 0; i < crs_pkg::LANE_COUNT; i++) begin
         m = (lane_mod[i] < 2) ? crs_pkg::MODULUS_BITS'(1) : lane_mod[i];
         if (restart) begin
            lane_rem[i] = seed_reg % m;
         end
         wide = 128'(lane_rem[i] % m);
         if (!too_large) begin
            wide = (wide * 128'(scale) + 128'(term)) % 128'(m);
         end
         lane_rem[i] = crs_pkg::MODULUS_BITS'(wide);
         hit[i] = !too_large && (wide == 0);
      end
      flags.divides_a      = hit[0];
      flags.divides_b      = hit[1];
      flags.divides_c      = hit[2];
      flags.divides_d      = hit[3];
      flags.term_too_large = too_large;
      return flags;
   endfunction

   function automatic void csr_apply(input logic [crs_pkg::CSR_IDX_BITS-1:0] index,
                                     input logic [crs_pkg::CSR_DATA_BITS-1:0] data);
      if (index < crs_pkg::LANE_COUNT) begin
         lane_mod[index] = data[crs_pkg::MODULUS_BITS-1:0];
      end else if (index == crs_pkg::SEED_INDEX) begin
         seed_reg = data[crs_pkg::SEED_BITS-1:0];
      end
   endfunction

   function automatic int pick_gap();
      int unsigned r;
      if (calm_phase) begin
         return 0;
      end
      r = $urandom_range(0, 15);
      if (r < 8) begin
         return 0;
      end else if (r < 13) begin
         return $urandom_range(1, 3);
      end else if (r < 15) begin
         return $urandom_range(4, 8);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [crs_pkg::MODULUS_BITS-1:0] pick_modulus(input bit small_only);
      int unsigned r;
      r = small_only ? 5 : $urandom_range(0, 9);
      case (r)
         0: begin
            return crs_pkg::MODULUS_BITS'($urandom_range(0, 2));
         end
         1: begin
            return MODULUS_MAX;
         end
         2: begin
            return crs_pkg::MODULUS_BITS'({$urandom(), $urandom()});
         end
         3: begin
            return crs_pkg::MODULUS_BITS'($urandom_range(2, 30) * 2);
         end
         4: begin
            return crs_pkg::MODULUS_BITS'($urandom_range(3, 999) | 1);
         end
         default: begin
            return crs_pkg::MODULUS_BITS'(SMALL_PRIMES[$urandom_range(0, 7)]);
         end
      endcase
   endfunction

   // upper data bits are junk that the seed register must drop
   function automatic logic [crs_pkg::CSR_DATA_BITS-1:0] pick_seed_word();
      logic [crs_pkg::SEED_BITS-1:0] seed;
      case ($urandom_range(0, 7))
         0: seed = '0;
         1: seed = SEED_MAX;
         2: seed = crs_pkg::SEED_RESET;
         3: seed = crs_pkg::SEED_BITS'($urandom());
         default: seed = crs_pkg::SEED_BITS'($urandom_range(0, 999999999));
      endcase
      return crs_pkg::CSR_DATA_BITS'({32'($urandom()), seed});
   endfunction

   function automatic logic [crs_pkg::TERM_BITS-1:0] pick_term();
      int unsigned digits;
      int unsigned lo;
      int unsigned hi;
      if ($urandom_range(0, 15) == 0) begin
         return crs_pkg::TERM_BITS'($urandom_range(1000000000,
                                                   (1 << crs_pkg::TERM_BITS) - 1));
      end
      digits = $urandom_range(1, 9);
      hi = 1;
      for (int k = 0; k < digits; k++) begin
         hi = hi * 10;
      end
      lo = (digits == 1) ? 0 : hi / 10;
      return crs_pkg::TERM_BITS'($urandom_range(hi - 1, lo));
   endfunction

   task automatic push_term(input logic [crs_pkg::TERM_BITS-1:0] term, input logic restart,
                            input logic typed = 1'b0,
                            input sieve_flags_type flags = NO_FLAGS);
      sieve_flags_type predicted;
      int              gap;
      req_if.valid   <= 1'b1;
      req_if.term    <= term;
      req_if.restart <= restart;
      do @(posedge clock); while (!req_if.ready);
      predicted = sieve_predict(term, restart);
      flags_due.push_back(typed ? flags : predicted);
      items_sent++;
      if (restart) restarts_sent++;
      if (term >= TOO_LARGE_AT) too_large_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (flags_due.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [crs_pkg::CSR_IDX_BITS-1:0] index,
                            input logic [crs_pkg::CSR_DATA_BITS-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      csr_apply(index, data);
      csr_writes++;
   endtask

   // all five registers in a rotated order, sometimes a poke at an unused index
   task automatic load_setup(input logic [crs_pkg::MODULUS_BITS-1:0] mods [crs_pkg::LANE_COUNT],
                             input logic [crs_pkg::CSR_DATA_BITS-1:0] seed_word,
                             input bit poke_unused);
      int unsigned start;
      int unsigned idx;
      wait_idle();
      start = $urandom_range(0, crs_pkg::LANE_COUNT);
      for (int k = 0; k <= crs_pkg::LANE_COUNT; k++) begin
         idx = (k + start) % (crs_pkg::LANE_COUNT + 1);
         if (idx == crs_pkg::LANE_COUNT) begin
            csr_write(crs_pkg::SEED_INDEX, seed_word);
         end else begin
            csr_write(crs_pkg::CSR_IDX_BITS'(idx), crs_pkg::CSR_DATA_BITS'(mods[idx]));
         end
      end
      if (poke_unused) begin
         csr_write(crs_pkg::CSR_IDX_BITS'($urandom_range(crs_pkg::LANE_COUNT + 1,
                                                         (1 << crs_pkg::CSR_IDX_BITS) - 1)),
                   crs_pkg::CSR_DATA_BITS'({$urandom(), $urandom()}));
      end
      csr_if.valid <= 1'b0;
   endtask

   function automatic void check_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s expected %0b got %0b", name, want, got);
         errors++;
      end
   endfunction

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int stall_left;
      bit squeeze_done;
      stall_left   = 0;
      squeeze_done = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze_rsp && !squeeze_done) begin
            squeeze_done = 1'b1;
            stall_left   = SQUEEZE_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (flags_due.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
         end else begin
            due_flags = flags_due.pop_front();
            check_field("divides_a", due_flags.divides_a, rsp_if.divides_a);
            check_field("divides_b", due_flags.divides_b, rsp_if.divides_b);
            check_field("divides_c", due_flags.divides_c, rsp_if.divides_c);
            check_field("divides_d", due_flags.divides_d, rsp_if.divides_d);
            check_field("term_too_large", due_flags.term_too_large, rsp_if.term_too_large);
            results_checked++;
            lane_hits += due_flags.divides_a + due_flags.divides_b
                       + due_flags.divides_c + due_flags.divides_d;
         end
      end
   end

   // no word moving on any channel for too long means the block hung
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      logic [crs_pkg::MODULUS_BITS-1:0] mods [crs_pkg::LANE_COUNT];
      errors          = 0;
      quiet_cycles    = 0;
      items_sent      = 0;
      restarts_sent   = 0;
      too_large_sent  = 0;
      csr_writes      = 0;
      results_checked = 0;
      lane_hits       = 0;
      calm_phase      = 1'b0;
      squeeze_rsp     = 1'b0;
      for (int i = 0; i < crs_pkg::LANE_COUNT; i++) begin
         lane_mod[i] = crs_pkg::MODULUS_RESET;
         lane_rem[i] = '0;
      end
      seed_reg = crs_pkg::SEED_RESET;

      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.term    <= '0;
      req_if.restart <= 1'b0;
      csr_if.valid   <= 1'b0;
      csr_if.index   <= '0;
      csr_if.data    <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: every digit-count boundary, too-large terms, restarts
      for (int k = 0; k < DIRECTED_COUNT; k++) begin
         push_term(DIRECTED_ROWS[k].term, DIRECTED_ROWS[k].restart,
                   DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].flags);
      end

      // moduli zero, one, even and full width, largest seed behind junk upper bits
      mods = '{crs_pkg::MODULUS_BITS'(0), crs_pkg::MODULUS_BITS'(1),
               crs_pkg::MODULUS_BITS'(2), MODULUS_MAX};
      load_setup(mods, crs_pkg::CSR_DATA_BITS'({32'hFFFF_FFFF, SEED_MAX}), 1'b1);
      push_term(crs_pkg::TERM_BITS'(0), 1'b1);
      push_term(crs_pkg::TERM_BITS'(999999999), 1'b0);
      push_term(TOO_LARGE_AT, 1'b0);

      // seed zero and term zero make a concatenation of zero
      mods = '{MODULUS_MAX, crs_pkg::MODULUS_BITS'(3), crs_pkg::MODULUS_BITS'(7),
               crs_pkg::MODULUS_BITS'(0)};
      load_setup(mods, crs_pkg::CSR_DATA_BITS'(0), 1'b0);
      push_term(crs_pkg::TERM_BITS'(0), 1'b1, 1'b1, ALL_DIVIDE);
      push_term(TERM_MAX, 1'b0, 1'b1, TOO_LARGE);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         for (int i = 0; i < crs_pkg::LANE_COUNT; i++) begin
            mods[i] = pick_modulus(p == PHASE_COUNT - 1);
         end
         load_setup(mods, pick_seed_word(), bit'($urandom_range(0, 1)));
         calm_phase = (p == 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 3 && i == 30) squeeze_rsp = 1'b1;
            if (p == 4 && i == 36) wait_idle();
            // first term after new moduli runs on the stale residues
            push_term(pick_term(), (i != 0) && ($urandom_range(0, 7) == 0));
         end
      end
      calm_phase = 1'b0;

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (flags_due.size() != 0) begin
         $error("%0d results never arrived", flags_due.size());
         errors += flags_due.size();
      end

      $display("sent %0d terms (%0d with restart, %0d too large) across %0d register writes",
               items_sent, restarts_sent, too_large_sent, csr_writes);
      $display("checked %0d result words, %0d lane divisibility hits",
               results_checked, lane_hits);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
